@@ design/mfb_pkg.sv @@
// ----------------------------------------------------------------------------
// mfb_pkg
// shared codes, types and helpers for the monochrome frame buffer line drawer
// ----------------------------------------------------------------------------
package mfb_pkg;

    // default canvas size
    localparam int DEF_CANVAS_WIDTH  = 128;
    localparam int DEF_CANVAS_HEIGHT = 64;

    // command codes
    localparam logic [2:0] FUNC_PIXEL = 3'd0;
    localparam logic [2:0] FUNC_LINE  = 3'd1;
    localparam logic [2:0] FUNC_FILL  = 3'd2;
    localparam logic [2:0] FUNC_CLEAR = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // color codes
    localparam logic [1:0] PEN_CLEAR = 2'd0;
    localparam logic [1:0] PEN_SET   = 2'd1;
    localparam logic [1:0] PEN_FLIP  = 2'd2;

    localparam logic [7:0] BYTE_FULL  = 8'hFF;
    localparam logic [7:0] BYTE_EMPTY = 8'h00;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch a new command
        logic sweep_wr;   // write one byte of a fill or clear sweep
        logic div_step;   // one step of the slope divider
        logic px_rd;      // read the byte under the current pixel
        logic px_wr;      // write back the modified byte, advance
        logic rd_issue;   // read the byte for readout
        logic out_load;   // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic div_last;
        logic line_last;
        logic out_busy;
    } t_status;

    // bytes in the store for a given canvas
    function automatic int store_bytes(input int w, input int h);
        return w * ((h + 7) / 8);
    endfunction

endpackage

@@ design/monochrome_framebuffer_line_draw_unit.sv @@
// ----------------------------------------------------------------------------
// monochrome_framebuffer_line_draw_unit
// page-organized one-bit frame store with pixel, line, fill, clear and readout
// ----------------------------------------------------------------------------
// steps: a pixel is one read-modify-write; a line runs the slope divider,
//   then one per pixel; read loads the output; fill or clear sweeps the store
// throughput: one command at a time; the read-modify-write of the
//   registered-read store sets the line rate, the byte sweep sets fill and clear
// reset: synchronous, active low; afterwards a clearing pass of one byte per
//   cycle holds the input stalled
// ----------------------------------------------------------------------------
module monochrome_framebuffer_line_draw_unit
    import mfb_pkg::*;
#(
    parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_func,
    input  logic [7:0] i_x_start,
    input  logic [7:0] i_y_start,
    input  logic [7:0] i_x_end,
    input  logic [7:0] i_y_end,
    input  logic [1:0] i_color,
    input  logic [9:0] i_byte_index,
    // readout channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data
);

    t_cmd    cmd;
    t_status status;

    // sequencer: one command per transfer, held busy until the store is done
    mfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // store, divider, stepper; the output register lets the next command in
    // while a read byte waits for its transfer
    mfb_datapath #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_func),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_color      (i_color),
        .i_byte_index (i_byte_index),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_read_data  (o_read_data)
    );

endmodule

@@ design/mfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// mfb_ctrl
// command sequencer: sweep, divide, read-modify-write and readout states
// ----------------------------------------------------------------------------
module mfb_ctrl
    import mfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_func,
    input  t_status    i_status,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_SWEEP  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_PREAD  = 3'd3;
    localparam logic [2:0] S_PWRITE = 3'd4;
    localparam logic [2:0] S_RREAD  = 3'd5;
    localparam logic [2:0] S_ROUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_func)
                        FUNC_PIXEL: n_state = S_PREAD;
                        FUNC_LINE:  n_state = S_DIV;
                        FUNC_FILL:  n_state = S_SWEEP;
                        FUNC_CLEAR: n_state = S_SWEEP;
                        FUNC_READ:  n_state = S_RREAD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_PREAD;
                end
            end
            S_PREAD: begin
                o_cmd.px_rd = 1'b1;
                n_state     = S_PWRITE;
            end
            S_PWRITE: begin
                o_cmd.px_wr = 1'b1;
                n_state     = i_status.line_last ? S_IDLE : S_PREAD;
            end
            S_RREAD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_ROUT;
            end
            S_ROUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/mfb_datapath.sv @@
// ----------------------------------------------------------------------------
// mfb_datapath
// frame store, slope divider, pixel stepper and readout register
// ----------------------------------------------------------------------------
module mfb_datapath
    import mfb_pkg::*;
#(
    parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [2:0] i_func,
    input  logic [7:0] i_x_start,
    input  logic [7:0] i_y_start,
    input  logic [7:0] i_x_end,
    input  logic [7:0] i_y_end,
    input  logic [1:0] i_color,
    input  logic [9:0] i_byte_index,
    input  logic       i_out_stall,
    output t_status    o_status,
    output logic       o_out_valid,
    output logic [7:0] o_read_data
);

    localparam int STORE_BYTES = store_bytes(CANVAS_WIDTH, CANVAS_HEIGHT);
    localparam int AW          = $clog2(STORE_BYTES);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    logic [7:0] r_x;
    logic [9:0] r_y;          // two's complement, may leave the canvas
    logic [7:0] r_cnt;
    logic       r_vert;
    logic       r_neg;
    logic [7:0] r_dx;
    logic [7:0] r_quot;
    logic [7:0] r_rem;
    logic [2:0] r_div_cnt;
    logic [7:0] r_racc;
    logic [1:0] r_color;
    logic [9:0] r_bidx;
    logic       r_fill;
    logic [AW-1:0] r_sweep;
    logic       r_out_valid;
    logic [7:0] r_out_data;

    // endpoint swap as a pair, spans and direction
    logic       swap;
    logic [7:0] xa, ya, xb, yb, dx, ady, ylo, yhi, vspan;

    always_comb begin
        swap  = (i_x_end < i_x_start);
        xa    = swap ? i_x_end   : i_x_start;
        ya    = swap ? i_y_end   : i_y_start;
        xb    = swap ? i_x_start : i_x_end;
        yb    = swap ? i_y_start : i_y_end;
        dx    = xb - xa;
        ady   = (yb < ya) ? (ya - yb) : (yb - ya);
        ylo   = (i_y_start < i_y_end) ? i_y_start : i_y_end;
        yhi   = (i_y_start < i_y_end) ? i_y_end   : i_y_start;
        vspan = yhi - ylo;
    end

    // restoring divider step: |dy| / dx
    logic [8:0] div_trial;
    assign div_trial = {r_rem, r_quot[7]};

    // y advance on a sloped line: quotient plus carry of the remainder sum
    logic [8:0] racc_sum;
    logic       racc_carry;
    logic [9:0] y_step;
    assign racc_sum   = {1'b0, r_racc} + {1'b0, r_rem};
    assign racc_carry = (racc_sum >= {1'b0, r_dx});
    assign y_step     = {2'b00, r_quot} + {9'd0, racc_carry};

    // current pixel address and canvas test
    logic          in_canvas;
    logic [AW-1:0] px_addr;
    logic [7:0]    px_mask;
    logic [7:0]    px_new;
    assign in_canvas = (32'(r_x) < 32'(CANVAS_WIDTH)) && !r_y[9]
                     && (32'(r_y[8:0]) < 32'(CANVAS_HEIGHT));
    assign px_addr   = AW'(32'(r_y[7:3]) * 32'(CANVAS_WIDTH) + 32'(r_x));
    assign px_mask   = 8'd1 << r_y[2:0];

    always_comb begin
        unique case (r_color)
            PEN_CLEAR: px_new = r_rdata & ~px_mask;
            PEN_SET:   px_new = r_rdata | px_mask;
            PEN_FLIP:  px_new = r_rdata ^ px_mask;
            default:   px_new = r_rdata;
        endcase
    end

    logic          bidx_ok;
    logic [AW-1:0] bidx_addr;
    assign bidx_ok   = (32'(r_bidx) < 32'(STORE_BYTES));
    assign bidx_addr = AW'(32'(r_bidx));

    // frame store, one write and one read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_wr) begin
            r_mem[r_sweep] <= r_fill ? BYTE_FULL : BYTE_EMPTY;
        end else if (i_cmd.px_wr && in_canvas) begin
            r_mem[px_addr] <= px_new;
        end
        if (i_cmd.px_rd) begin
            r_rdata <= r_mem[px_addr];
        end else if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[bidx_addr];
        end
    end

    // sweep control and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= '0;
            r_fill      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_sweep <= '0;
                r_fill  <= (i_func == FUNC_FILL);
            end else if (i_cmd.sweep_wr) begin
                r_sweep <= r_sweep + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // operands, divider and pixel stepper
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_color   <= i_color;
            r_bidx    <= i_byte_index;
            r_dx      <= dx;
            r_neg     <= (yb < ya);
            r_quot    <= ady;
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_racc    <= '0;
            if (i_func == FUNC_PIXEL) begin
                r_vert <= 1'b1;
                r_x    <= i_x_start;
                r_y    <= {2'b00, i_y_start};
                r_cnt  <= 8'd1;
            end else if (dx == 8'd0) begin
                r_vert <= 1'b1;
                r_x    <= xa;
                r_y    <= {2'b00, ylo};
                r_cnt  <= (vspan == 8'd0) ? 8'd1 : vspan;
            end else begin
                r_vert <= 1'b0;
                r_x    <= xa;
                r_y    <= {2'b00, ya};
                r_cnt  <= dx;
            end
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 3'd1;
            if (div_trial >= {1'b0, r_dx}) begin
                r_rem  <= 8'(div_trial - {1'b0, r_dx});
                r_quot <= {r_quot[6:0], 1'b1};
            end else begin
                r_rem  <= div_trial[7:0];
                r_quot <= {r_quot[6:0], 1'b0};
            end
        end else if (i_cmd.px_wr) begin
            r_cnt <= r_cnt - 8'd1;
            if (r_vert) begin
                r_y <= r_y + 10'd1;
            end else begin
                r_x    <= r_x + 8'd1;
                r_racc <= racc_carry ? 8'(racc_sum - {1'b0, r_dx}) : racc_sum[7:0];
                r_y    <= r_neg ? (r_y - y_step) : (r_y + y_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= bidx_ok ? r_rdata : BYTE_EMPTY;
        end
    end

    assign o_status.sweep_last = (r_sweep == AW'(STORE_BYTES - 1));
    assign o_status.div_last   = (r_div_cnt == 3'd7);
    assign o_status.line_last  = (r_cnt == 8'd1);
    assign o_status.out_busy   = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

@@ design/mfb_checker.sv @@
// ----------------------------------------------------------------------------
// mfb_checker
// port-level checks for the frame buffer line drawer
// ----------------------------------------------------------------------------
module mfb_checker
    import mfb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [2:0] i_func,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_read_data
);

    // the clearing pass follows every reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data))
        else $error("stalled result changed");

    // every defined command sends the block busy once it is taken
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall
        && (i_func == FUNC_PIXEL || i_func == FUNC_LINE || i_func == FUNC_FILL
            || i_func == FUNC_CLEAR || i_func == FUNC_READ)
        |=> o_in_stall)
        else $error("command accepted without going busy");

    // a result only appears at the end of a read, while the input is stalled
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while idle");

endmodule

bind monochrome_framebuffer_line_draw_unit mfb_checker u_mfb_checker (.*);

@@ verif/tb_monochrome_framebuffer_line_draw_unit.sv @@
// ----------------------------------------------------------------------------
// tb_monochrome_framebuffer_line_draw_unit
// self-checking bench for the page-organized monochrome frame store
// ----------------------------------------------------------------------------
// a short table of directed commands (reset contents, fill and clear, canvas
// edges, every color, every line shape, unused codes) is followed by random
// command streams built around reads of recently drawn bytes. a shadow copy
// of the frame store predicts every readout byte; both channels idle at
// random, and the readout side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_monochrome_framebuffer_line_draw_unit;
    import mfb_pkg::*;

    localparam int CANVAS_W       = DEF_CANVAS_WIDTH;
    localparam int CANVAS_H       = DEF_CANVAS_HEIGHT;
    localparam int STORE_BYTES    = CANVAS_W * ((CANVAS_H + 7) / 8);
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 600;
    localparam int GAP_PERCENT    = 19;
    localparam int STEADY_FIRST   = 200;
    localparam int STEADY_LAST    = 349;
    localparam int HOLD_AT        = 450;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 40;
    // must outlast the quiet stretch of a fill or clear sweep or of a long line
    localparam int WATCHDOG_LIMIT = 5000;

    // codes the package leaves unnamed
    localparam logic [1:0] PEN_KEEP    = 2'd3;
    localparam logic [2:0] FUNC_SPARE5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    // one command, plus a hand-typed readout where one is obvious
    typedef struct {
        logic [2:0] func;
        logic [7:0] xs;
        logic [7:0] ys;
        logic [7:0] xe;
        logic [7:0] ye;
        logic [1:0] color;
        logic [9:0] idx;
        bit         pinned;
        logic [7:0] pinned_byte;
    } t_draw_cmd;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [2:0] i_func;
    logic [7:0] i_x_start;
    logic [7:0] i_y_start;
    logic [7:0] i_x_end;
    logic [7:0] i_y_end;
    logic [1:0] i_color;
    logic [9:0] i_byte_index;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_read_data;

    // shadow of the frame store and the readout bytes still owed
    logic [7:0] shadow_frame [STORE_BYTES];
    logic [7:0] expected_bytes [$];
    logic [7:0] wanted_byte;
    t_draw_cmd  directed_rows [$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    bit steady       = 1'b0;  // no gaps on either side
    bit hold_req     = 1'b0;  // raised by the stimulus
    bit hold_taken   = 1'b0;  // raised by the readout side

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    monochrome_framebuffer_line_draw_unit #(
        .CANVAS_WIDTH  (CANVAS_W),
        .CANVAS_HEIGHT (CANVAS_H)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_color      (i_color),
        .i_byte_index (i_byte_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data)
    );

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- shadow

    function automatic void plot_pixel(input int x, input int y, input logic [1:0] color);
        int         idx;
        logic [7:0] mask;
        // off-canvas pixels are dropped one by one
        if (x < 0 || x >= CANVAS_W || y < 0 || y >= CANVAS_H) return;
        idx  = (y / 8) * CANVAS_W + x;
        mask = 8'd1 << (y % 8);
        case (color)
            PEN_SET:   shadow_frame[idx] = shadow_frame[idx] | mask;
            PEN_CLEAR: shadow_frame[idx] = shadow_frame[idx] & ~mask;
            PEN_FLIP:  shadow_frame[idx] = shadow_frame[idx] ^ mask;
            default: ;
        endcase
    endfunction

    function automatic void trace_line(input int xa, input int ya, input int xb,
                                       input int yb, input logic [1:0] color);
        int t;
        int lo;
        int hi;
        int pos;
        int dx;
        int dy;
        // endpoints swap as a pair so the line keeps its direction
        if (xb < xa) begin
            t = xa; xa = xb; xb = t;
            t = ya; ya = yb; yb = t;
        end
        if (xa == xb) begin
            // vertical: half-open at the far end, a lone point still draws
            lo  = (ya < yb) ? ya : yb;
            hi  = (ya < yb) ? yb : ya;
            pos = lo;
            do begin
                plot_pixel(xa, pos, color);
                pos++;
            end while (pos < hi);
        end else if (ya == yb) begin
            for (pos = xa; pos < xb; pos++) plot_pixel(pos, ya, color);
        end else begin
            // signed divide truncates toward zero, same as the block
            dx = xb - xa;
            dy = yb - ya;
            for (pos = 0; pos < dx; pos++) plot_pixel(xa + pos, ya + (pos * dy) / dx, color);
        end
    endfunction

    function automatic void apply_to_shadow(input t_draw_cmd c, output bit has_byte,
                                            output logic [7:0] byte_val);
        has_byte = 1'b0;
        byte_val = BYTE_EMPTY;
        case (c.func)
            FUNC_PIXEL: plot_pixel(c.xs, c.ys, c.color);
            FUNC_LINE:  trace_line(c.xs, c.ys, c.xe, c.ye, c.color);
            FUNC_FILL:  foreach (shadow_frame[i]) shadow_frame[i] = BYTE_FULL;
            FUNC_CLEAR: foreach (shadow_frame[i]) shadow_frame[i] = BYTE_EMPTY;
            FUNC_READ: begin
                has_byte = 1'b1;
                byte_val = (c.idx < STORE_BYTES) ? shadow_frame[c.idx] : BYTE_EMPTY;
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- sender

    function automatic t_draw_cmd row(input logic [2:0] func, input int xs, input int ys,
                                      input int xe, input int ye, input logic [1:0] color,
                                      input int idx, input bit pinned,
                                      input logic [7:0] pinned_byte);
        t_draw_cmd c;
        c.func        = func;
        c.xs          = 8'(xs);
        c.ys          = 8'(ys);
        c.xe          = 8'(xe);
        c.ye          = 8'(ye);
        c.color       = color;
        c.idx         = 10'(idx);
        c.pinned      = pinned;
        c.pinned_byte = pinned_byte;
        return c;
    endfunction

    function automatic logic [7:0] near_coord(input logic [7:0] origin);
        int t;
        t = int'(origin) + int'($urandom_range(48)) - 24;
        return (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : 8'(t);
    endfunction

    // offers one command and waits for its transfer; valid stays up for a
    // following command unless that one starts with a gap
    task automatic send_command(input t_draw_cmd c);
        bit         has_byte;
        logic [7:0] byte_val;
        while (!steady && $urandom_range(99) < GAP_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= c.func;
        i_x_start    <= c.xs;
        i_y_start    <= c.ys;
        i_x_end      <= c.xe;
        i_y_end      <= c.ye;
        i_color      <= c.color;
        i_byte_index <= c.idx;
        do @(posedge i_clk); while (o_in_stall);
        // transfer happened at this edge
        apply_to_shadow(c, has_byte, byte_val);
        if (has_byte) expected_bytes.push_back(c.pinned ? c.pinned_byte : byte_val);
    endtask

    // ---------------------------------------------------------------- readout side

    // random stalls, none in the steady window, and one long hold-off that
    // lets a read sit in the output register while commands keep coming
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= !steady && ($urandom_range(99) < GAP_PERCENT);
        end
    end

    // every readout transfer must match the oldest owed byte
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("readout 0x%02h with nothing pending", o_read_data));
            end else begin
                wanted_byte = expected_bytes.pop_front();
                if (o_read_data !== wanted_byte)
                    report_mismatch($sformatf("read_data 0x%02h, expected 0x%02h",
                                              o_read_data, wanted_byte));
            end
        end
    end

    // ends a hung run: counts cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_monochrome_framebuffer_line_draw_unit: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        t_draw_cmd c;
        int        counted;
        int        pick;
        int        shape;
        int        last_x;
        int        last_y;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_func       <= FUNC_PIXEL;
        i_x_start    <= 8'd0;
        i_y_start    <= 8'd0;
        i_x_end      <= 8'd0;
        i_y_end      <= 8'd0;
        i_color      <= PEN_CLEAR;
        i_byte_index <= 10'd0;
        foreach (shadow_frame[i]) shadow_frame[i] = BYTE_EMPTY;

        //                       func        xs   ys   xe   ye  color      idx pin value
        directed_rows.push_back(row(FUNC_READ,    0,   0,   0,   0, PEN_CLEAR,     0, 1, 8'h00));
        directed_rows.push_back(row(FUNC_READ,    0,   0,   0,   0, PEN_CLEAR,  1023, 1, 8'h00));
        directed_rows.push_back(row(FUNC_FILL,    0,   0,   0,   0, PEN_CLEAR,     0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_READ,    0,   0,   0,   0, PEN_CLEAR,     0, 1, 8'hFF));
        // far corner pixel is bit 7 of the last byte
        directed_rows.push_back(row(FUNC_PIXEL, 127,  63,   0,   0, PEN_CLEAR,     0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_READ,    0,   0,   0,   0, PEN_CLEAR,  1023, 1, 8'h7F));
        // just off the right edge and just below the bottom: must not alias
        directed_rows.push_back(row(FUNC_PIXEL, 128,   0,   0,   0, PEN_CLEAR,     0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_PIXEL,   0,  64,   0,   0, PEN_CLEAR,     0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_READ,    0,   0,   0,   0, PEN_CLEAR,   128, 1, 8'hFF));
        directed_rows.push_back(row(FUNC_CLEAR,   0,   0,   0,   0, PEN_CLEAR,     0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_PIXEL,   0,   0,   0,   0, PEN_SET,       0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_READ,    0,   0,   0,   0, PEN_CLEAR,     0, 1, 8'h01));
        directed_rows.push_back(row(FUNC_PIXEL,   0,   0,   0,   0, PEN_FLIP,      0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_PIXEL,   0,   1,   0,   0, PEN_FLIP,      0, 0, 8'h00));
        // color three changes nothing
        directed_rows.push_back(row(FUNC_PIXEL,   0,   1,   0,   0, PEN_KEEP,      0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_READ,    0,   0,   0,   0, PEN_CLEAR,     0, 1, 8'h02));
        // vertical, then horizontal given right to left
        directed_rows.push_back(row(FUNC_LINE,   10,   5,  10,  20, PEN_SET,       0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_READ,    0,   0,   0,   0, PEN_CLEAR,   138, 0, 8'h00));
        directed_rows.push_back(row(FUNC_LINE,   20,  30,   5,  30, PEN_SET,       0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_READ,    0,   0,   0,   0, PEN_CLEAR,   389, 0, 8'h00));
        // descending diagonal, then a swapped one running far off the canvas
        directed_rows.push_back(row(FUNC_LINE,    0,  63, 127,   0, PEN_FLIP,      0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_LINE,  255, 255,   0,   0, PEN_SET,       0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_LINE,    3,   3,   3,   3, PEN_CLEAR,     0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_SPARE5,  1,   1,   1,   1, PEN_SET,       0, 0, 8'h00));
        directed_rows.push_back(row(FUNC_READ,    0,   0,   0,   0, PEN_CLEAR,     0, 0, 8'h00));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the clearing pass after reset shows up as a stalled first transfer
        foreach (directed_rows[i]) send_command(directed_rows[i]);

        // random part: ignored codes are sent but not counted
        counted = 0;
        last_x  = 0;
        last_y  = 0;
        while (counted < RANDOM_ITEMS) begin
            steady = (counted >= STEADY_FIRST && counted <= STEADY_LAST);
            if (counted == HOLD_AT) hold_req = 1'b1;

            c.xs          = 8'($urandom_range(255));
            c.ys          = 8'($urandom_range(255));
            c.xe          = 8'($urandom_range(255));
            c.ye          = 8'($urandom_range(255));
            c.color       = 2'($urandom_range(3));
            c.idx         = 10'($urandom_range(1023));
            c.pinned      = 1'b0;
            c.pinned_byte = BYTE_EMPTY;
            // mostly on the canvas or just past its edges
            if ($urandom_range(99) < 80) begin
                c.xs = 8'($urandom_range(CANVAS_W + 7));
                c.ys = 8'($urandom_range(CANVAS_H + 7));
            end

            pick = $urandom_range(99);
            if (pick < 30) begin
                c.func = FUNC_READ;
                // half the reads look where the last drawing went
                if ($urandom_range(1) == 0)
                    c.idx = 10'(((last_y % CANVAS_H) / 8) * CANVAS_W + (last_x % CANVAS_W));
            end else if (pick < 55) begin
                c.func = FUNC_PIXEL;
            end else if (pick < 80) begin
                c.func = FUNC_LINE;
                // short lines keep the run fast; some span the whole range
                if ($urandom_range(99) < 70) begin
                    c.xe = near_coord(c.xs);
                    c.ye = near_coord(c.ys);
                end
                shape = $urandom_range(99);
                if (shape < 15)
                    c.xe = c.xs;
                else if (shape < 30)
                    c.ye = c.ys;
            end else if (pick < 83) begin
                c.func = FUNC_FILL;
            end else if (pick < 87) begin
                c.func = FUNC_CLEAR;
            end else begin
                case ($urandom_range(2))
                    0:       c.func = FUNC_SPARE5;
                    1:       c.func = FUNC_SPARE6;
                    default: c.func = FUNC_SPARE7;
                endcase
            end

            if (c.func == FUNC_PIXEL || c.func == FUNC_LINE) begin
                last_x = int'(c.xs);
                last_y = int'(c.ys);
            end
            if (c.func <= FUNC_READ) counted++;
            send_command(c);
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        // drain: every owed byte, then a margin for a late stray transfer
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("tb_monochrome_framebuffer_line_draw_unit: done, clean");
        end else begin
            $display("tb_monochrome_framebuffer_line_draw_unit: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/mfb_pkg.sv
design/mfb_ctrl.sv
design/mfb_datapath.sv
design/monochrome_framebuffer_line_draw_unit.sv
design/mfb_checker.sv
verif/tb_monochrome_framebuffer_line_draw_unit.sv
